FILE: hw/rtl/i2cmts_pkg.sv
`timescale 1ns / 1ps

package i2cmts_pkg;

	// Transmit FIFO geometry
	localparam int TX_DEPTH = 32;
	localparam int HEAD_W   = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int CNT_W    = $clog2(TX_DEPTH + 1);
	localparam int SUM_W    = CNT_W + 1;

	localparam logic [6:0] SLAVE_ADDR_RST = 7'h01;

	// Command modes
	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_EVENT = 2'd2
	} mode_t;

	// Bus actions
	typedef enum logic [2:0] {
		ACT_NONE  = 3'd0,
		ACT_START = 3'd1,
		ACT_SEND  = 3'd2,
		ACT_CONT  = 3'd3,
		ACT_STOP  = 3'd4
	} action_t;

	// Two-wire master status codes
	localparam logic [7:0] ST_START        = 8'h08;
	localparam logic [7:0] ST_REP_START    = 8'h10;
	localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
	localparam logic [7:0] ST_MT_SLA_NACK  = 8'h20;
	localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
	localparam logic [7:0] ST_MT_DATA_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST     = 8'h38;
	localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
	localparam logic [7:0] ST_MR_SLA_NACK  = 8'h48;
	localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
	localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;

	// One result item
	typedef struct packed {
		logic       reject;
		action_t    bus_action;
		logic [7:0] out_byte;
		logic       ack_next;
		logic       rx_valid;
		logic [7:0] rx_data;
		logic       busy_res;
		logic       error;
	} result_t;

endpackage

FILE: hw/rtl/i2cmts_if.sv
`timescale 1ns / 1ps

// Command / status event channel
interface i2cmts_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] tx_byte;
	logic       last_byte;
	logic [7:0] read_length;
	logic [7:0] status_code;
	logic [7:0] rx_byte;

	modport source (output valid, mode, tx_byte, last_byte, read_length, status_code, rx_byte,
		input ready);
	modport sink (input valid, mode, tx_byte, last_byte, read_length, status_code, rx_byte,
		output ready);
endinterface

// Result channel
interface i2cmts_res_if;
	logic       valid;
	logic       ready;
	logic       reject;
	logic [2:0] bus_action;
	logic [7:0] out_byte;
	logic       ack_next;
	logic       rx_valid;
	logic [7:0] rx_data;
	logic       busy_res;
	logic       error;

	modport source (output valid, reject, bus_action, out_byte, ack_next, rx_valid, rx_data,
		busy_res, error, input ready);
	modport sink (input valid, reject, bus_action, out_byte, ack_next, rx_valid, rx_data,
		busy_res, error, output ready);
endinterface

// Configuration write channel
interface i2cmts_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] slave_address;

	modport source (output valid, slave_address, input ready);
	modport sink (input valid, slave_address, output ready);
endinterface

FILE: hw/rtl/i2cmts_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module i2cmts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hw/rtl/i2c_master_transfer_sequencer_core.sv
`timescale 1ns / 1ps

// Byte-level I2C master sequencer.
// cmd: one item per transfer; mode selects queue write byte, start read, or
//   a bus status event from the bit engine. Every item yields exactly one
//   result on res (bus action, byte to send, ack for the next byte, received
//   byte, busy and sticky error).
// cfg: 7-bit slave address; always ready, write it while the block is idle.
// Path: a result is registered in stage 1, then in the output register that drives res.
// Throughput: one item per cycle unless both stages hold unaccepted results. All
//   control state updates in the accept cycle; the transmit FIFO memory read
//   issued then is registered, which sets the two-stage depth.
// Stalls: a stage behind the output register keeps cmd ready while one
//   result waits; ready drops only when both stages hold unaccepted results.
// Reset: FIFO empty, idle, error clear, write direction, slave address 1.
//   FIFO memory contents are not cleared; only queued entries are read.

module i2c_master_transfer_sequencer_core
	import i2cmts_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	i2cmts_cmd_if.sink   cmd,
	i2cmts_res_if.source res,
	i2cmts_cfg_if.sink   cfg
);

	// Control state
	logic [HEAD_W-1:0] tx_head_q, tx_head_n;
	logic [CNT_W-1:0]  tx_count_q, tx_count_n;
	logic              busy_q, busy_n;
	logic              error_q, error_n;
	logic              reading_q, reading_n;
	logic [7:0]        read_target_q, read_target_n;
	logic [7:0]        read_received_q, read_received_n;
	logic              ack_en_q, ack_en_n;
	logic [6:0]        slave_address_q;

	// Pipeline
	logic    v_s1, use_ram_s1;
	result_t res_s1, res_n;
	logic    use_ram_n;
	logic    v_out_q;
	result_t res_out_q;

	logic accept, s1_adv;
	logic fifo_we;
	logic [7:0] ram_rdata;
	logic [SUM_W-1:0] wsum;
	logic [HEAD_W-1:0] waddr;
	logic [7:0] rr_inc;

	// Handshakes
	assign cfg.ready = 1'b1;
	assign s1_adv    = v_s1 && (!v_out_q || res.ready);
	assign cmd.ready = !v_s1 || s1_adv;
	assign accept    = cmd.valid && cmd.ready;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_address_q <= SLAVE_ADDR_RST;
		end else if (cfg.valid) begin
			slave_address_q <= cfg.slave_address;
		end
	end

	// FIFO tail address: (head + count) mod depth
	assign wsum  = SUM_W'(tx_head_q) + SUM_W'(tx_count_q);
	assign waddr = (wsum >= SUM_W'(TX_DEPTH)) ? HEAD_W'(wsum - SUM_W'(TX_DEPTH))
		: HEAD_W'(wsum);
	assign rr_inc = (read_received_q == 8'hFF) ? read_received_q : read_received_q + 8'd1;

	// Decision logic on the accepted item
	always_comb begin
		tx_head_n       = tx_head_q;
		tx_count_n      = tx_count_q;
		busy_n          = busy_q;
		error_n         = error_q;
		reading_n       = reading_q;
		read_target_n   = read_target_q;
		read_received_n = read_received_q;
		ack_en_n        = ack_en_q;
		fifo_we         = 1'b0;
		use_ram_n       = 1'b0;
		res_n           = '0;
		res_n.bus_action = ACT_NONE;

		case (cmd.mode)
			MODE_WRITE: begin
				if (busy_q || tx_count_q == CNT_W'(TX_DEPTH)) begin
					res_n.reject = 1'b1;
				end else begin
					fifo_we    = 1'b1;
					tx_count_n = tx_count_q + CNT_W'(1);
					if (cmd.last_byte) begin
						reading_n        = 1'b0;
						busy_n           = 1'b1;
						res_n.bus_action = ACT_START;
					end
				end
			end
			MODE_READ: begin
				if (busy_q || tx_count_q != '0) begin
					res_n.reject = 1'b1;
				end else begin
					reading_n        = 1'b1;
					read_target_n    = (cmd.read_length == 8'd0) ? 8'd1 : cmd.read_length;
					read_received_n  = 8'd0;
					ack_en_n         = 1'b1;
					busy_n           = 1'b1;
					res_n.bus_action = ACT_START;
				end
			end
			MODE_EVENT: begin
				case (cmd.status_code)
					ST_START, ST_REP_START: begin
						res_n.bus_action = ACT_SEND;
						res_n.out_byte   = {slave_address_q, reading_q};
					end
					ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
						if (tx_count_q != '0) begin
							res_n.bus_action = ACT_SEND;
							use_ram_n        = 1'b1;
							tx_count_n       = tx_count_q - CNT_W'(1);
							tx_head_n        = (tx_head_q == HEAD_W'(TX_DEPTH - 1)) ? '0
								: tx_head_q + HEAD_W'(1);
						end else begin
							res_n.bus_action = ACT_STOP;
							busy_n           = 1'b0;
							ack_en_n         = 1'b0;
						end
					end
					ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
						res_n.bus_action = ACT_STOP;
						error_n    = 1'b1;
						busy_n     = 1'b0;
						ack_en_n   = 1'b0;
						tx_head_n  = '0;
						tx_count_n = '0;
					end
					ST_MR_SLA_ACK: begin
						if (read_target_q == 8'd1) begin
							ack_en_n = 1'b0;
						end
						res_n.bus_action = ACT_CONT;
					end
					ST_MR_DATA_ACK: begin
						res_n.rx_valid  = 1'b1;
						res_n.rx_data   = cmd.rx_byte;
						read_received_n = rr_inc;
						if (rr_inc == read_target_q - 8'd1) begin
							ack_en_n = 1'b0;
						end
						res_n.bus_action = ACT_CONT;
					end
					ST_MR_DATA_NACK: begin
						res_n.rx_valid   = 1'b1;
						res_n.rx_data    = cmd.rx_byte;
						read_received_n  = rr_inc;
						res_n.bus_action = ACT_STOP;
						busy_n           = 1'b0;
						ack_en_n         = 1'b0;
					end
					default: begin
						// arbitration lost or unknown code
						error_n    = 1'b1;
						busy_n     = 1'b0;
						ack_en_n   = 1'b0;
						tx_head_n  = '0;
						tx_count_n = '0;
					end
				endcase
			end
			default: begin
			end
		endcase

		res_n.ack_next = ack_en_n;
		res_n.busy_res = busy_n;
		res_n.error    = error_n;
	end

	// State update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_head_q       <= '0;
			tx_count_q      <= '0;
			busy_q          <= 1'b0;
			error_q         <= 1'b0;
			reading_q       <= 1'b0;
			read_target_q   <= 8'd1;
			read_received_q <= 8'd0;
			ack_en_q        <= 1'b0;
		end else if (accept) begin
			tx_head_q       <= tx_head_n;
			tx_count_q      <= tx_count_n;
			busy_q          <= busy_n;
			error_q         <= error_n;
			reading_q       <= reading_n;
			read_target_q   <= read_target_n;
			read_received_q <= read_received_n;
			ack_en_q        <= ack_en_n;
		end
	end

	// Transmit FIFO storage. A pop never reads the entry written by the
	// same item, and earlier writes land at earlier edges, so no forwarding.
	// The read is enabled only on accept, so rdata holds while stage 1 stalls.
	i2cmts_ram #(
		.WIDTH (8),
		.DEPTH (TX_DEPTH)
	) u_tx_ram (
		.clk   (clk),
		.we    (accept && fifo_we),
		.waddr (waddr),
		.wdata (cmd.tx_byte),
		.re    (accept),
		.raddr (tx_head_q),
		.rdata (ram_rdata)
	);

	// Stage 1: waits for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1     <= res_n;
			use_ram_s1 <= use_ram_n;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (s1_adv) begin
			v_out_q <= 1'b1;
		end else if (res.ready) begin
			v_out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_out_q <= res_s1;
			if (use_ram_s1) begin
				res_out_q.out_byte <= ram_rdata;
			end
		end
	end

	assign res.valid      = v_out_q;
	assign res.reject     = res_out_q.reject;
	assign res.bus_action = res_out_q.bus_action;
	assign res.out_byte   = res_out_q.out_byte;
	assign res.ack_next   = res_out_q.ack_next;
	assign res.rx_valid   = res_out_q.rx_valid;
	assign res.rx_data    = res_out_q.rx_data;
	assign res.busy_res   = res_out_q.busy_res;
	assign res.error      = res_out_q.error;

endmodule

FILE: hw/rtl/i2cmts_chk.sv
`timescale 1ns / 1ps

module i2cmts_chk
	import i2cmts_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_reject,
	input logic [2:0] res_bus_action,
	input logic [7:0] res_out_byte,
	input logic       res_rx_valid,
	input logic [7:0] res_rx_data,
	input logic       res_error
);

	logic [1:0] pending_q;
	logic       err_seen_q;
	logic       cmd_xfer, res_xfer;

	assign cmd_xfer = cmd_valid && cmd_ready;
	assign res_xfer = res_valid && res_ready;

	// Items accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q  <= 2'd0;
			err_seen_q <= 1'b0;
		end else begin
			pending_q <= pending_q + 2'(cmd_xfer) - 2'(res_xfer);
			if (res_xfer && res_error) begin
				err_seen_q <= 1'b1;
			end
		end
	end

	// Never more than two results in flight, and none without a command
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q != 2'd3) && (!res_valid || pending_q != 2'd0))
		else $error("result count out of step with commands");

	// Stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_out_byte)
		&& $stable(res_bus_action))
		else $error("stalled result changed");

	// Error flag is sticky across transfers
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && err_seen_q |-> res_error)
		else $error("error flag dropped");

	// Refused command causes no bus action and no data
	a_reject: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_reject |-> res_bus_action == ACT_NONE && !res_rx_valid)
		else $error("rejected command drove the bus");

	// Received data is zero unless flagged
	a_rxdata: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_rx_valid |-> res_rx_data == 8'd0)
		else $error("stray receive data");

endmodule

bind i2c_master_transfer_sequencer_core i2cmts_chk u_i2cmts_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.cmd_valid      (cmd.valid),
	.cmd_ready      (cmd.ready),
	.res_valid      (res.valid),
	.res_ready      (res.ready),
	.res_reject     (res.reject),
	.res_bus_action (res.bus_action),
	.res_out_byte   (res.out_byte),
	.res_rx_valid   (res.rx_valid),
	.res_rx_data    (res.rx_data),
	.res_error      (res.error)
);

FILE: tb/sv/i2c_master_transfer_sequencer_core_tb.sv
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_core_tb;
	import i2cmts_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int QUIET_LIMIT = 5000;
	localparam int PHASE_ITEMS = 350;
	localparam int NUM_PHASES = 5;

	typedef struct {
		logic [1:0] mode;
		logic [7:0] tx_byte;
		logic       last_byte;
		logic [7:0] read_length;
		logic [7:0] status_code;
		logic [7:0] rx_byte;
	} cmd_item_t;

	typedef struct {
		cmd_item_t item;
		bit        typed;
		result_t   want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	i2cmts_cmd_if cmd_ch ();
	i2cmts_res_if res_ch ();
	i2cmts_cfg_if cfg_ch ();

	i2c_master_transfer_sequencer_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	// Sequencer shadow state
	logic [7:0]        fifo_mem [TX_DEPTH];
	logic [HEAD_W-1:0] fifo_head;
	logic [CNT_W-1:0]  fifo_count;
	logic              busy_q;
	logic              error_q;
	logic              rd_dir;
	logic [7:0]        rd_target;
	logic [7:0]        rd_got;
	logic              ack_en;
	logic [6:0]        addr_q;

	result_t   decision_q [$];
	stim_row_t directed_rows [$];
	int        mismatch_count = 0;
	int        results_seen = 0;
	int        items_sent = 0;
	int        quiet_cycles = 0;
	int        hold_cnt = 0;
	int        gap_pct = 0;
	int        stall_pct = 0;
	bit        calm = 0;
	result_t   got_res;
	result_t   want_res;

	always #5 clk = ~clk;

	// End of transfer on error: flag, release, flush
	function automatic void abort_transfer();
		error_q = 1'b1;
		busy_q = 1'b0;
		ack_en = 1'b0;
		fifo_head = '0;
		fifo_count = '0;
	endfunction

	function automatic result_t predict_bus_decision(cmd_item_t c);
		result_t r;
		logic [HEAD_W-1:0] slot;
		r = '0;
		case (c.mode)
			MODE_WRITE: begin
				if (busy_q || fifo_count >= TX_DEPTH) begin
					r.reject = 1'b1;
				end else begin
					slot = fifo_head + fifo_count[HEAD_W-1:0];
					fifo_mem[slot] = c.tx_byte;
					fifo_count = fifo_count + 1'b1;
					if (c.last_byte) begin
						rd_dir = 1'b0;
						busy_q = 1'b1;
						r.bus_action = ACT_START;
					end
				end
			end
			MODE_READ: begin
				if (busy_q || fifo_count != 0) begin
					r.reject = 1'b1;
				end else begin
					rd_dir = 1'b1;
					rd_target = (c.read_length == 8'd0) ? 8'd1 : c.read_length;
					rd_got = 8'd0;
					ack_en = 1'b1;
					busy_q = 1'b1;
					r.bus_action = ACT_START;
				end
			end
			MODE_EVENT: begin
				case (c.status_code)
					ST_START, ST_REP_START: begin
						r.bus_action = ACT_SEND;
						r.out_byte = {addr_q, rd_dir};
					end
					ST_MT_SLA_ACK, ST_MT_DATA_ACK: begin
						if (fifo_count != 0) begin
							r.bus_action = ACT_SEND;
							r.out_byte = fifo_mem[fifo_head];
							fifo_head = fifo_head + 1'b1;
							fifo_count = fifo_count - 1'b1;
						end else begin
							r.bus_action = ACT_STOP;
							busy_q = 1'b0;
							ack_en = 1'b0;
						end
					end
					ST_MT_SLA_NACK, ST_MT_DATA_NACK, ST_MR_SLA_NACK: begin
						r.bus_action = ACT_STOP;
						abort_transfer();
					end
					ST_MR_SLA_ACK: begin
						// single-byte read: NACK the first data byte
						if (rd_target == 8'd1)
							ack_en = 1'b0;
						r.bus_action = ACT_CONT;
					end
					ST_MR_DATA_ACK: begin
						r.rx_valid = 1'b1;
						r.rx_data = c.rx_byte;
						if (rd_got != 8'hFF)
							rd_got = rd_got + 8'd1;
						if (rd_got == rd_target - 8'd1)
							ack_en = 1'b0;
						r.bus_action = ACT_CONT;
					end
					ST_MR_DATA_NACK: begin
						r.rx_valid = 1'b1;
						r.rx_data = c.rx_byte;
						if (rd_got != 8'hFF)
							rd_got = rd_got + 8'd1;
						r.bus_action = ACT_STOP;
						busy_q = 1'b0;
						ack_en = 1'b0;
					end
					default: begin
						abort_transfer();
					end
				endcase
			end
			default: begin
			end
		endcase
		r.ack_next = ack_en;
		r.busy_res = busy_q;
		r.error = error_q;
		return r;
	endfunction

	function automatic cmd_item_t mk_cmd(logic [1:0] mode, logic [7:0] txb, logic last,
			logic [7:0] rlen, logic [7:0] code, logic [7:0] rxb);
		cmd_item_t c;
		c.mode = mode;
		c.tx_byte = txb;
		c.last_byte = last;
		c.read_length = rlen;
		c.status_code = code;
		c.rx_byte = rxb;
		return c;
	endfunction

	function automatic result_t mk_res(logic rej, action_t act, logic [7:0] ob, logic ack,
			logic rxv, logic [7:0] rxd, logic busy, logic err);
		result_t r;
		r.reject = rej;
		r.bus_action = act;
		r.out_byte = ob;
		r.ack_next = ack;
		r.rx_valid = rxv;
		r.rx_data = rxd;
		r.busy_res = busy;
		r.error = err;
		return r;
	endfunction

	function automatic logic [7:0] rnd8();
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_status();
		case ($urandom_range(0, 10))
			0:       return ST_START;
			1:       return ST_REP_START;
			2:       return ST_MT_SLA_ACK;
			3:       return ST_MT_SLA_NACK;
			4:       return ST_MT_DATA_ACK;
			5:       return ST_MT_DATA_NACK;
			6:       return ST_ARB_LOST;
			7:       return ST_MR_SLA_ACK;
			8:       return ST_MR_SLA_NACK;
			9:       return ST_MR_DATA_ACK;
			default: return ST_MR_DATA_NACK;
		endcase
	endfunction

	function automatic logic [7:0] pick_fault();
		case ($urandom_range(0, 4))
			0:       return ST_MT_SLA_NACK;
			1:       return ST_MT_DATA_NACK;
			2:       return ST_MR_SLA_NACK;
			3:       return ST_ARB_LOST;
			default: return rnd8();
		endcase
	endfunction

	// Present one item, wait for its transfer, then record the expected decision
	task automatic send_item(cmd_item_t c, bit typed, result_t typed_res);
		int gap;
		result_t predicted;
		gap = 0;
		if (!calm && $urandom_range(0, 99) < gap_pct)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= c.mode;
		cmd_ch.tx_byte <= c.tx_byte;
		cmd_ch.last_byte <= c.last_byte;
		cmd_ch.read_length <= c.read_length;
		cmd_ch.status_code <= c.status_code;
		cmd_ch.rx_byte <= c.rx_byte;
		do @(posedge clk); while (!cmd_ch.ready);
		predicted = predict_bus_decision(c);
		decision_q.push_back(typed ? typed_res : predicted);
		if (c.mode != MODE_SPARE)
			items_sent++;
	endtask

	task automatic write_address(logic [6:0] a);
		cfg_ch.valid <= 1'b1;
		cfg_ch.slave_address <= a;
		do @(posedge clk); while (!cfg_ch.ready);
		addr_q = a;
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (decision_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Play a status event sequence; occasionally cut it short with a fault
	// or drop an event to break the protocol
	task automatic play_events(logic [7:0] codes [$]);
		int cut;
		int i;
		cut = codes.size();
		if ($urandom_range(0, 99) < 15) begin
			cut = $urandom_range(0, codes.size() - 1);
			codes[cut] = pick_fault();
			cut = cut + 1;
		end
		for (i = 0; i < cut; i++) begin
			if ($urandom_range(0, 99) < 3)
				continue;
			send_item(mk_cmd(MODE_EVENT, rnd8(), 1'($urandom_range(0, 1)), rnd8(),
				codes[i], rnd8()), 1'b0, '0);
		end
	endtask

	task automatic write_transfer();
		int n;
		int i;
		logic [7:0] codes [$];
		// mostly short, now and then past the FIFO depth
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 36) : $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			send_item(mk_cmd(MODE_WRITE, rnd8(), i == n - 1, rnd8(), rnd8(), rnd8()),
				1'b0, '0);
		codes.push_back(($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START);
		codes.push_back(ST_MT_SLA_ACK);
		for (i = 0; i < n; i++)
			codes.push_back(ST_MT_DATA_ACK);
		play_events(codes);
	endtask

	task automatic read_transfer();
		int len;
		int eff;
		int i;
		int sel;
		logic [7:0] codes [$];
		sel = $urandom_range(0, 99);
		if (sel < 85)
			len = $urandom_range(1, 5);
		else if (sel < 95)
			len = 0;
		else
			len = $urandom_range(0, 255);
		eff = (len == 0) ? 1 : len;
		send_item(mk_cmd(MODE_READ, rnd8(), 1'($urandom_range(0, 1)), 8'(len), rnd8(),
			rnd8()), 1'b0, '0);
		codes.push_back(($urandom_range(0, 3) == 0) ? ST_REP_START : ST_START);
		codes.push_back(ST_MR_SLA_ACK);
		for (i = 1; i < eff; i++)
			codes.push_back(ST_MR_DATA_ACK);
		codes.push_back(ST_MR_DATA_NACK);
		play_events(codes);
	endtask

	task automatic noise_burst();
		logic [7:0] code;
		repeat ($urandom_range(1, 4)) begin
			code = $urandom_range(0, 1) ? pick_status() : rnd8();
			send_item(mk_cmd(2'($urandom_range(0, 3)), rnd8(), 1'($urandom_range(0, 1)),
				rnd8(), code, rnd8()), 1'b0, '0);
		end
	endtask

	task automatic add_row(cmd_item_t c, bit typed, result_t want);
		stim_row_t row;
		row.item = c;
		row.typed = typed;
		row.want = want;
		directed_rows.push_back(row);
	endtask

	// Result check against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			got_res.reject = res_ch.reject;
			got_res.bus_action = action_t'(res_ch.bus_action);
			got_res.out_byte = res_ch.out_byte;
			got_res.ack_next = res_ch.ack_next;
			got_res.rx_valid = res_ch.rx_valid;
			got_res.rx_data = res_ch.rx_data;
			got_res.busy_res = res_ch.busy_res;
			got_res.error = res_ch.error;
			if (decision_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%t: result %0d arrived with nothing expected", $realtime,
						results_seen);
			end else begin
				want_res = decision_q.pop_front();
				if (got_res.reject !== want_res.reject ||
						got_res.bus_action !== want_res.bus_action ||
						got_res.out_byte !== want_res.out_byte ||
						got_res.ack_next !== want_res.ack_next ||
						got_res.rx_valid !== want_res.rx_valid ||
						got_res.rx_data !== want_res.rx_data ||
						got_res.busy_res !== want_res.busy_res ||
						got_res.error !== want_res.error) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("%t: result %0d mismatch", $realtime, results_seen);
						$display("  exp rej=%0d act=%0d byte=%h ack=%0d rxv=%0d rxd=%h busy=%0d err=%0d",
							want_res.reject, want_res.bus_action, want_res.out_byte,
							want_res.ack_next, want_res.rx_valid, want_res.rx_data,
							want_res.busy_res, want_res.error);
						$display("  got rej=%0d act=%0d byte=%h ack=%0d rxv=%0d rxd=%h busy=%0d err=%0d",
							got_res.reject, got_res.bus_action, got_res.out_byte,
							got_res.ack_next, got_res.rx_valid, got_res.rx_data,
							got_res.busy_res, got_res.error);
					end
				end
			end
		end
	end

	// Random result-side stalls in bursts
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			res_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
			hold_cnt <= $urandom_range(0, 8);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int p;
		int r;
		int phase_end;
		int pick;

		clk = 1'b0;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.slave_address = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = MODE_WRITE;
		cmd_ch.tx_byte = '0;
		cmd_ch.last_byte = 1'b0;
		cmd_ch.read_length = '0;
		cmd_ch.status_code = '0;
		cmd_ch.rx_byte = '0;

		// shadow state at reset
		fifo_head = '0;
		fifo_count = '0;
		busy_q = 1'b0;
		error_q = 1'b0;
		rd_dir = 1'b0;
		rd_target = 8'd1;
		rd_got = 8'd0;
		ack_en = 1'b0;
		addr_q = SLAVE_ADDR_RST;

		// Directed stimulus, slave address at its reset value
		add_row(mk_cmd(MODE_SPARE, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF), 1'b1,
			mk_res(0, ACT_NONE, 8'h00, 0, 0, 8'h00, 0, 0));
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_START, 8'h00), 1'b1,
			mk_res(0, ACT_SEND, 8'h02, 0, 0, 8'h00, 0, 0));
		add_row(mk_cmd(MODE_WRITE, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, ACT_NONE, 8'h00, 0, 0, 8'h00, 0, 0));
		add_row(mk_cmd(MODE_WRITE, 8'hFF, 1'b0, 8'hFF, 8'hFF, 8'hFF), 1'b1,
			mk_res(0, ACT_NONE, 8'h00, 0, 0, 8'h00, 0, 0));
		// read refused while bytes are queued
		add_row(mk_cmd(MODE_READ, 8'h00, 1'b0, 8'd4, 8'h00, 8'h00), 1'b1,
			mk_res(1, ACT_NONE, 8'h00, 0, 0, 8'h00, 0, 0));
		add_row(mk_cmd(MODE_WRITE, 8'hA5, 1'b1, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, ACT_START, 8'h00, 0, 0, 8'h00, 1, 0));
		// commands refused while busy
		add_row(mk_cmd(MODE_WRITE, 8'h3C, 1'b1, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(1, ACT_NONE, 8'h00, 0, 0, 8'h00, 1, 0));
		add_row(mk_cmd(MODE_READ, 8'h00, 1'b0, 8'd1, 8'h00, 8'h00), 1'b1,
			mk_res(1, ACT_NONE, 8'h00, 0, 0, 8'h00, 1, 0));
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_START, 8'h00), 1'b1,
			mk_res(0, ACT_SEND, 8'h02, 0, 0, 8'h00, 1, 0));
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MT_SLA_ACK, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MT_DATA_ACK, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MT_DATA_ACK, 8'h00), 1'b0, '0);
		// FIFO empty: stop
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MT_DATA_ACK, 8'h00), 1'b0, '0);
		// zero length read behaves as one byte
		add_row(mk_cmd(MODE_READ, 8'h00, 1'b0, 8'd0, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_REP_START, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MR_SLA_ACK, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MR_DATA_NACK, 8'hFF), 1'b0, '0);
		add_row(mk_cmd(MODE_READ, 8'h00, 1'b0, 8'd255, 8'h00, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MR_SLA_ACK, 8'h00), 1'b0, '0);
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MR_DATA_ACK, 8'h00), 1'b0, '0);
		// lost arbitration mid read, then NACKs while idle
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_ARB_LOST, 8'h00), 1'b1,
			mk_res(0, ACT_NONE, 8'h00, 0, 0, 8'h00, 0, 1));
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MT_SLA_NACK, 8'h00), 1'b1,
			mk_res(0, ACT_STOP, 8'h00, 0, 0, 8'h00, 0, 1));
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MT_DATA_NACK, 8'h00), 1'b1,
			mk_res(0, ACT_STOP, 8'h00, 0, 0, 8'h00, 0, 1));
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, ST_MR_SLA_NACK, 8'h00), 1'b1,
			mk_res(0, ACT_STOP, 8'h00, 0, 0, 8'h00, 0, 1));
		// unknown status code
		add_row(mk_cmd(MODE_EVENT, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00), 1'b1,
			mk_res(0, ACT_NONE, 8'h00, 0, 0, 8'h00, 0, 1));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct = 25;
		stall_pct = 25;
		for (r = 0; r < directed_rows.size(); r++)
			send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
		drain();

		// Random phases, each with its own address and idling mix
		for (p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin write_address(7'h7F); gap_pct = 30; stall_pct = 30; end
				1: begin write_address(7'h00); gap_pct = 0;  stall_pct = 50; end
				2: begin write_address(7'($urandom_range(0, 127))); gap_pct = 50; stall_pct = 0; end
				3: begin write_address(7'($urandom_range(0, 127))); gap_pct = 15; stall_pct = 15; end
				default: begin write_address(7'($urandom_range(0, 127))); calm = 1; end
			endcase
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					write_transfer();
				else if (pick < 75)
					read_transfer();
				else
					noise_burst();
			end
			drain();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && decision_q.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
